// File: hw/rtl/sdf_pkg.sv
// Shared types, operation codes and saturation helpers for the smooth damp follower.
package sdf_pkg;

	localparam int MW  = 33;   // multiplier operand width (signed)
	localparam int PW  = 2 * MW; // product width
	localparam int DVW = 34;   // divisor width
	localparam int OPW = 5;

	typedef logic [OPW-1:0] op_t;

	// Shared setup sequence
	localparam op_t OP_DIVO    = 5'd0;
	localparam op_t OP_WOMEGA  = 5'd1;
	localparam op_t OP_MXDT    = 5'd2;
	localparam op_t OP_WX      = 5'd3;
	localparam op_t OP_MXX     = 5'd4;
	localparam op_t OP_WX2     = 5'd5;
	localparam op_t OP_MX2X    = 5'd6;
	localparam op_t OP_WX3     = 5'd7;
	localparam op_t OP_MK48    = 5'd8;
	localparam op_t OP_WDEN1   = 5'd9;
	localparam op_t OP_MK235   = 5'd10;
	localparam op_t OP_WDEN2   = 5'd11;
	localparam op_t OP_DIVE    = 5'd12;
	localparam op_t OP_WEX     = 5'd13;
	localparam op_t OP_MMS     = 5'd14;
	localparam op_t OP_WMC     = 5'd15;
	// Per-axis sequence
	localparam op_t OP_CHG     = 5'd16;
	localparam op_t OP_T2      = 5'd17;
	localparam op_t OP_MOC     = 5'd18;
	localparam op_t OP_WACC1   = 5'd19;
	localparam op_t OP_MACCDT  = 5'd20;
	localparam op_t OP_WTEMP   = 5'd21;
	localparam op_t OP_MOT     = 5'd22;
	localparam op_t OP_WACC2   = 5'd23;
	localparam op_t OP_MNV     = 5'd24;
	localparam op_t OP_WNV     = 5'd25;
	localparam op_t OP_MOUT    = 5'd26;
	localparam op_t OP_WOUT    = 5'd27;
	localparam op_t OP_SNAP    = 5'd28;

	typedef struct packed {
		logic load;
		logic exec;
		op_t  op;
		logic axis;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

	function automatic logic signed [PW-1:0] sx(input logic signed [31:0] v);
		return {{(PW-32){v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		logic [PW-32:0] hi;
		hi = v[PW-1:31];
		if ((&hi) || (~|hi))
			return v[31:0];
		else if (v[PW-1])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

	function automatic logic [31:0] capu(input logic [PW-1:0] v);
		if (|v[PW-1:31])
			return 32'h7fff_ffff;
		else
			return {1'b0, v[30:0]};
	endfunction

endpackage

// File: hw/rtl/sdf_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module sdf_div #(
	parameter int NW = 34,
	parameter int DW = 34
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo,
	output logic          done
);
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   rem_sh;
	logic          ge;

	assign rem_sh = {rem_q[DW-1:0], quo_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule

// File: hw/rtl/sdf_ctrl.sv
// Sequencer that walks the operation program of the smooth damp follower.
module sdf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  sdf_pkg::status_t status,
	output sdf_pkg::cmd_t   cmd
);
	import sdf_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DWAIT = 2'd2;
	localparam logic [1:0] ST_PUSH  = 2'd3;

	logic [1:0] state_q;
	op_t        pc_q;
	logic       axis_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load = s_tvalid && (state_q == ST_IDLE);
		cmd.exec = (state_q == ST_RUN);
		cmd.op   = pc_q;
		cmd.axis = axis_q;
		cmd.push = (state_q == ST_PUSH) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= OP_DIVO;
			axis_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_RUN;
						pc_q    <= OP_DIVO;
						axis_q  <= 1'b0;
					end
				end
				ST_RUN: begin
					if (pc_q inside {OP_DIVO, OP_DIVE}) begin
						state_q <= ST_DWAIT;
					end else if (pc_q == OP_SNAP) begin
						if (!axis_q) begin
							axis_q <= 1'b1;
							pc_q   <= OP_CHG;
						end else begin
							state_q <= ST_PUSH;
						end
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				ST_DWAIT: begin
					if (status.div_done) begin
						state_q <= ST_RUN;
						pc_q    <= pc_q + 1'b1;
					end
				end
				ST_PUSH: begin
					if (status.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> state_q == ST_DWAIT)
		else $error("divider finished outside of a wait");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> status.out_free)
		else $error("push into an occupied output register");

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_RUN && pc_q == OP_DIVO && !axis_q)
		else $error("accepted transfer did not start the program");
endmodule

// File: hw/rtl/sdf_dp.sv
// Datapath: shared multiplier, divider, working registers, state and output register.
module sdf_dp #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sdf_pkg::cmd_t    cmd,
	output sdf_pkg::status_t status,
	input  logic [175:0]     s_tdata,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [63:0]      m_tdata
);
	import sdf_pkg::*;

	localparam int NW = 2 * FRAC_BITS + 2;
	localparam logic [63:0] ST_MIN = ((64'd1 << FRAC_BITS) + 64'd9999) / 64'd10000;
	localparam logic [63:0] K48    = ((64'd48 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam logic [63:0] K235   = ((64'd235 << FRAC_BITS) + 64'd500) / 64'd1000;

	logic [31:0]        max_speed_q;
	logic signed [31:0] vel_q [2];
	logic signed [31:0] cur_q [2];
	logic signed [31:0] tgt_q [2];
	logic signed [31:0] ox_q  [2];
	logic [23:0]        st_q;
	logic [16:0]        dt_q;
	logic [31:0]        om_q, x_q, x2_q, x3_q, mc_q;
	logic [DVW-1:0]     den_q;
	logic [FRAC_BITS:0] ex_q;
	logic signed [31:0] chg_q, t2_q, acc_q, temp_q, sum_q, nv_q, res_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic               m_tvalid_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] p_s1;
	logic signed [PW-1:0] psh;

	logic          div_start;
	logic [NW-1:0] div_num;
	logic [DVW-1:0] div_den;
	logic [NW-1:0] div_quo;
	logic          div_done;

	logic signed [31:0] v, cur, tgt, diff, mcs;
	logic [23:0]        st_in;

	assign v    = vel_q[cmd.axis];
	assign cur  = cur_q[cmd.axis];
	assign tgt  = tgt_q[cmd.axis];
	assign psh  = p_s1 >>> FRAC_BITS;
	assign diff = sat32(sx(cur) - sx(tgt));
	assign mcs  = mc_q;
	assign st_in = (s_tdata[151:128] < ST_MIN[23:0]) ? ST_MIN[23:0] : s_tdata[151:128];

	// Operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MXDT:   begin mul_a = MW'(om_q);       mul_b = MW'(dt_q); end
			OP_MXX:    begin mul_a = MW'(x_q);        mul_b = MW'(x_q); end
			OP_MX2X:   begin mul_a = MW'(x2_q);       mul_b = MW'(x_q); end
			OP_MK48:   begin mul_a = MW'(K48);        mul_b = MW'(x2_q); end
			OP_MK235:  begin mul_a = MW'(K235);       mul_b = MW'(x3_q); end
			OP_MMS:    begin mul_a = MW'(max_speed_q); mul_b = MW'(st_q); end
			OP_MOC:    begin mul_a = MW'(om_q);       mul_b = {chg_q[31], chg_q}; end
			OP_MACCDT: begin mul_a = {acc_q[31], acc_q}; mul_b = MW'(dt_q); end
			OP_MOT:    begin mul_a = MW'(om_q);       mul_b = {temp_q[31], temp_q}; end
			OP_MNV:    begin mul_a = {acc_q[31], acc_q}; mul_b = MW'(ex_q); end
			OP_MOUT:   begin mul_a = {sum_q[31], sum_q}; mul_b = MW'(ex_q); end
			default:   begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		p_s1 <= mul_a * mul_b;
	end

	always_comb begin
		div_start = cmd.exec && (cmd.op inside {OP_DIVO, OP_DIVE});
		if (cmd.op == OP_DIVO) begin
			div_num = NW'(1) << (2 * FRAC_BITS + 1);
			div_den = DVW'(st_q);
		end else begin
			div_num = NW'(1) << (2 * FRAC_BITS);
			div_den = den_q;
		end
	end

	sdf_div #(.NW(NW), .DW(DVW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q[0] <= s_tdata[31:0];
			cur_q[1] <= s_tdata[63:32];
			tgt_q[0] <= s_tdata[95:64];
			tgt_q[1] <= s_tdata[127:96];
			st_q     <= st_in;
			dt_q     <= s_tdata[168:152];
		end
		if (cmd.exec) begin
			case (cmd.op)
				OP_WOMEGA: om_q  <= capu(PW'(div_quo));
				OP_WX:     x_q   <= capu(psh);
				OP_WX2:    x2_q  <= capu(psh);
				OP_WX3:    x3_q  <= capu(psh);
				OP_WDEN1:  den_q <= DVW'(64'd1 << FRAC_BITS) + DVW'(x_q) + psh[DVW-1:0];
				OP_WDEN2:  den_q <= den_q + psh[DVW-1:0];
				OP_WEX:    ex_q  <= div_quo[FRAC_BITS:0];
				OP_WMC:    mc_q  <= capu(psh);
				OP_CHG: begin
					if (diff > mcs)
						chg_q <= mcs;
					else if (diff < -mcs)
						chg_q <= -mcs;
					else
						chg_q <= diff;
				end
				OP_T2:     t2_q   <= sat32(sx(cur) - sx(chg_q));
				OP_WACC1:  acc_q  <= sat32(sx(v) + sx(sat32(psh)));
				OP_WTEMP:  temp_q <= sat32(psh);
				OP_WACC2: begin
					acc_q <= sat32(sx(v) - sx(sat32(psh)));
					sum_q <= sat32(sx(chg_q) + sx(temp_q));
				end
				OP_WNV:    nv_q  <= sat32(psh);
				OP_WOUT:   res_q <= sat32(sx(t2_q) + psh);
				OP_SNAP: begin
					if ((tgt > cur) == (res_q > tgt))
						ox_q[cmd.axis] <= tgt;
					else
						ox_q[cmd.axis] <= res_q;
				end
				default: ;
			endcase
		end
		if (cmd.push) begin
			out_x_q <= ox_q[0];
			out_y_q <= ox_q[1];
		end
	end

	// Kept state, register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= 32'hffff_ffff;
			vel_q[0]    <= '0;
			vel_q[1]    <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				max_speed_q <= cfg_wdata;
			if (cmd.exec && cmd.op == OP_SNAP) begin
				if ((tgt > cur) == (res_q > tgt))
					vel_q[cmd.axis] <= '0;
				else
					vel_q[cmd.axis] <= nv_q;
			end
			if (cmd.push)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	assign status.div_done = div_done;
	assign status.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid        = m_tvalid_q;
	assign m_tdata         = {out_y_q, out_x_q};
endmodule

// File: hw/rtl/smooth_damp_follower_2d_top.sv
// Top level of the two-axis critically damped smooth damp follower.
// Each input transfer carries present and goal positions for x and y, a smooth time and a
// tick length; the block moves both axes toward the goal along a critically damped spring,
// keeping one velocity per axis, and returns one result transfer with the new positions.
// The two divisions (omega and the decay factor) run on one restoring divider at one
// quotient bit per cycle, and every product goes through a single shared 33x33
// multiplier, each with its own write-back step. Both divisions and the setup
// products are shared by the two axes. A finished result sits in the output register, so
// the next input transfer is accepted while it waits; the program stalls only if a second
// result is ready before the first has been taken. Write max_speed only while the block is
// idle.
module smooth_damp_follower_2d_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration: max_speed, unsigned Q16.16
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	// Input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// current_x[31:0], current_y[63:32], target_x[95:64], target_y[127:96],
	// smooth_time[151:128], delta_time[168:152], zero fill [175:169]
	input  logic [175:0] s_tdata,
	// Output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x[31:0], out_y[63:32]
	output logic [63:0]  m_tdata
);
	import sdf_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer: accept a transfer, walk the setup and per-axis program, push the result
	sdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: multiplier, divider, velocities, max_speed and output register
	sdf_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);
endmodule

// File: tb/testbench.sv
// Self-checking testbench for the two-axis smooth damp follower top level.
module testbench;

	localparam longint ST_FLOOR   = 7;       // smallest smooth time, about 0.0001 s
	localparam longint K_048      = 31457;   // 0.48 in Q16.16
	localparam longint K_0235     = 15401;   // 0.235 in Q16.16
	localparam longint S_MAX      = 64'sd2147483647;
	localparam longint S_MIN      = -64'sd2147483648;
	localparam int     CYCLE_CAP  = 2000000;
	localparam int     N_RANDOM   = 880;

	typedef struct {
		logic signed [31:0] cur_x, cur_y, tgt_x, tgt_y;
		logic [23:0]        smooth;
		logic [16:0]        dt;
	} tick_t;

	class follower_board;
		logic [31:0]        speed_cap = 32'hffff_ffff;
		longint             vel_x, vel_y;
		logic signed [31:0] out_q_x[$];
		logic signed [31:0] out_q_y[$];
		logic signed [31:0] last_x, last_y;
		int                 errors;

		function longint sat(longint v);
			if (v > S_MAX) return S_MAX;
			if (v < S_MIN) return S_MIN;
			return v;
		endfunction

		function longint cap(longint v);
			return (v > S_MAX) ? S_MAX : v;
		endfunction

		function longint damp_axis(longint cur, longint tgt, inout longint vel,
				input longint st, input longint dt);
			longint omega, x, x2, x3, den, decay, limit, chg, t2, oc, tmp, nv, pos;
			omega = cap((64'sd1 <<< 33) / st);
			x     = cap((omega * dt) >>> 16);
			x2    = cap((x * x) >>> 16);
			x3    = cap((x2 * x) >>> 16);
			den   = 65536 + x + ((K_048 * x2) >>> 16) + ((K_0235 * x3) >>> 16);
			decay = (64'sd1 <<< 32) / den;
			limit = cap((longint'(speed_cap) * st) >>> 16);
			chg   = sat(cur - tgt);
			if (chg > limit) chg = limit;
			if (chg < -limit) chg = -limit;
			t2  = sat(cur - chg);
			oc  = sat((omega * chg) >>> 16);
			tmp = sat((sat(vel + oc) * dt) >>> 16);
			nv  = sat((sat(vel - sat((omega * tmp) >>> 16)) * decay) >>> 16);
			pos = sat(t2 + ((sat(chg + tmp) * decay) >>> 16));
			// overshoot: snap onto the goal and stop
			if ((tgt - cur > 0) == (pos > tgt)) begin
				pos = tgt;
				nv  = 0;
			end
			vel = nv;
			return pos;
		endfunction

		function void note_tick(tick_t t);
			longint st;
			st = (t.smooth < ST_FLOOR) ? ST_FLOOR : longint'(t.smooth);
			last_x = damp_axis(t.cur_x, t.tgt_x, vel_x, st, t.dt);
			last_y = damp_axis(t.cur_y, t.tgt_y, vel_y, st, t.dt);
			out_q_x.push_back(last_x);
			out_q_y.push_back(last_y);
		endfunction

		function void check_result(logic [63:0] data);
			logic signed [31:0] ex, ey;
			if (out_q_x.size() == 0) begin
				$display("%0t: unexpected result %h", $time, data);
				errors++;
				return;
			end
			ex = out_q_x.pop_front();
			ey = out_q_y.pop_front();
			if (data[31:0] !== ex) begin
				$display("%0t: out_x expected %h actual %h", $time, ex, data[31:0]);
				errors++;
			end
			if (data[63:32] !== ey) begin
				$display("%0t: out_y expected %h actual %h", $time, ey, data[63:32]);
				errors++;
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_we = 0;
	logic [31:0]  cfg_wdata = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [175:0] s_tdata = 0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [63:0]  m_tdata;

	follower_board board = new();
	int            cycles;
	bit            quiet_phase;  // no idling on either side while set

	smooth_damp_follower_2d_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function int pick_gap();
		int r;
		if (quiet_phase) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Score each edge: check the result first, then record the new transfer.
	always @(posedge clk) begin
		cycles++;
		if (m_tvalid && m_tready) board.check_result(m_tdata);
		if (s_tvalid && s_tready) begin
			tick_t t;
			t.cur_x  = s_tdata[31:0];
			t.cur_y  = s_tdata[63:32];
			t.tgt_x  = s_tdata[95:64];
			t.tgt_y  = s_tdata[127:96];
			t.smooth = s_tdata[151:128];
			t.dt     = s_tdata[168:152];
			board.note_tick(t);
		end
		if (cycles > CYCLE_CAP) begin
			$display("FAIL smooth_damp_follower_2d_top");
			$finish;
		end
	end

	// Receiver: stall at random.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = pick_gap();
			if (g > 0) begin
				m_tready <= 0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	task automatic send_tick(tick_t t);
		int g;
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= {7'b0, t.dt, t.smooth, t.tgt_y, t.tgt_x, t.cur_y, t.cur_x};
		do @(posedge clk); while (!s_tready);
	endtask

	// Hold off until every result is back, then let the block settle.
	// Step one edge first so the last accepted transfer is already recorded.
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (board.out_q_x.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_speed(logic [31:0] v);
		drain();
		cfg_we    <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 0;
		board.speed_cap = v;
	endtask

	function automatic tick_t make_tick(logic signed [31:0] cx, cy, tx, ty,
			logic [23:0] st, logic [16:0] dt);
		tick_t t;
		t.cur_x = cx; t.cur_y = cy; t.tgt_x = tx; t.tgt_y = ty;
		t.smooth = st; t.dt = dt;
		return t;
	endfunction

	function automatic logic signed [31:0] near(logic signed [31:0] base);
		return base + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
	endfunction

	// Random tick: most follow the previous output toward a target, the rest are noise.
	function automatic tick_t random_tick();
		tick_t t;
		int    r;
		r = $urandom_range(99);
		if (r < 70) begin
			t.cur_x = board.last_x;
			t.cur_y = board.last_y;
			t.tgt_x = near(board.last_x);
			t.tgt_y = near(board.last_y);
		end else begin
			t.cur_x = $urandom; t.cur_y = $urandom;
			t.tgt_x = $urandom; t.tgt_y = $urandom;
		end
		r = $urandom_range(99);
		if (r < 60) t.smooth = 24'($urandom_range(3277, 196608));
		else if (r < 70) t.smooth = 24'($urandom_range(0, 8));
		else t.smooth = 24'($urandom);
		r = $urandom_range(99);
		if (r < 60) t.dt = 17'($urandom_range(500, 4400));
		else if (r < 90) t.dt = 17'($urandom_range(0, 65536));
		else t.dt = 17'($urandom);
		return t;
	endfunction

	initial begin
		logic signed [31:0] pmax, pmin;
		pmax = 32'sh7fff_ffff;
		pmin = 32'sh8000_0000;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: reset speed cap, field extremes, zero and tiny smooth time, zero tick.
		send_tick(make_tick(0, 0, 32'sh0001_0000, -32'sh0001_0000, 24'h008000, 17'd1092));
		send_tick(make_tick(board.last_x, board.last_y, 32'sh0001_0000, -32'sh0001_0000,
			24'h008000, 17'd1092));
		send_tick(make_tick(pmin, pmax, pmax, pmin, 24'hffffff, 17'h1ffff));
		send_tick(make_tick(pmax, pmin, pmin, pmax, 24'd0, 17'd65536));
		send_tick(make_tick(5, -5, 5, -5, 24'd6, 17'd0));
		send_tick(make_tick(0, 0, 32'sh0010_0000, 32'sh0010_0000, 24'd7, 17'd0));
		send_tick(make_tick(32'sh0010_0000, 0, 0, 32'sh0010_0000, 24'h010000, 17'd65536));
		send_tick(make_tick(-100, 100, 100, -100, 24'd1, 17'h1ffff));
		write_speed(32'd0);
		send_tick(make_tick(pmin, pmax, pmax, pmin, 24'h010000, 17'd1092));
		send_tick(make_tick(1000, -1000, 0, 0, 24'h000800, 17'd2184));
		write_speed(32'h0002_0000);
		send_tick(make_tick(0, 0, 32'sh0100_0000, -32'sh0100_0000, 24'h008000, 17'd1092));
		send_tick(make_tick(board.last_x, board.last_y, 32'sh0100_0000, -32'sh0100_0000,
			24'h008000, 17'd1092));
		send_tick(make_tick(board.last_x, board.last_y, 32'sh0100_0000, -32'sh0100_0000,
			24'h008000, 17'd65536));
		write_speed(32'hffff_ffff);
		send_tick(make_tick(pmax, pmax, pmin, pmin, 24'd0, 17'h1ffff));
		send_tick(make_tick(pmin, pmin, pmax, pmax, 24'hffffff, 17'd0));

		// Random phases at several speed caps, one stretch without idling.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_speed(32'h0010_0000);
				1: write_speed($urandom);
				2: write_speed(32'd1);
				3: write_speed(32'hffff_ffff);
				default: write_speed($urandom_range(0, 32'h0100_0000));
			endcase
			quiet_phase = (ph == 2);
			for (int i = 0; i < N_RANDOM / 5; i++) send_tick(random_tick());
		end
		quiet_phase = 0;

		s_tvalid <= 0;
		@(posedge clk);
		while (board.out_q_x.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0)
			$display("PASS smooth_damp_follower_2d_top");
		else
			$display("FAIL smooth_damp_follower_2d_top");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/sdf_pkg.sv
hw/rtl/sdf_div.sv
hw/rtl/sdf_ctrl.sv
hw/rtl/sdf_dp.sv
hw/rtl/smooth_damp_follower_2d_top.sv
tb/testbench.sv
